/* sv/tbt_pkg.sv */
// ============================================================================
// Timed byte transmitter package
// Shared request codes and fixed constants for the timed byte transmitter.
// ============================================================================
package tbt_pkg;

    // Request kinds carried on the input stream.
    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_RD_WORD  = 3'd1,
        REQ_RD_BYTE  = 3'd2,
        REQ_WR_WORD  = 3'd3,
        REQ_WR_BYTE  = 3'd4
    } t_req;

    // Field widths of one request and one result.
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned OFF_W    = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned BYTE_W   = 8;

    // The buffer is split into four byte lanes of one word each row.
    localparam int unsigned NUM_LANES = 4;

    // Control word occupies the first bytes of the window.
    localparam logic [OFF_W-1:0]   CTRL_BYTES  = 5'd4;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 16'hFFFF;

endpackage

/* sv/tbt_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ============================================================================
module tbt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; returns the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/timed_byte_transmitter_top.sv */
// ============================================================================
// Timed byte transmitter
// Memory-mapped control word and transmit buffer; ticks release buffer bytes
// one per tick once the armed delay has passed.
// ============================================================================
// A request accepted on the slave side passes through the request stage, where
// the buffer lanes are read, and then the result register before its result
// is valid on the master side.
// Throughput: one request per cycle while the result stream is not stalled; the
// buffer lane RAMs take one read and one write per cycle and a write-to-read bypass covers back-to-back accesses.
// Reset (synchronous, active low) disarms the device, clears both counters,
// loads start_delay with 1000 and clears the per-byte valid flags, so the
// buffer reads as zero at once without a clearing pass.
module timed_byte_transmitter_top #(
    parameter int unsigned BUF_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [4:0] offset, [36:5] write_data, rest zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] req_type

    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] read_data, [32] tx_valid,
                                          // [40:33] tx_byte, [41] busy_res, rest zero

    // Configuration write channel (start_delay).
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned LANES      = tbt_pkg::NUM_LANES;
    localparam int unsigned LANE_DEPTH = (BUF_BYTES + LANES - 1) / LANES;
    localparam int unsigned LAW        = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int unsigned BI_W       = $clog2(BUF_BYTES);
    localparam int unsigned BW         = (BI_W > tbt_pkg::OFF_W) ? BI_W : tbt_pkg::OFF_W;

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    logic                          s_acc;
    logic                          s1_adv;

    logic [tbt_pkg::REQ_W-1:0]     in_req;
    logic [tbt_pkg::OFF_W-1:0]     in_off;
    logic [tbt_pkg::OFF_W-1:0]     in_pos;
    logic                          in_ctrl;
    logic                          in_word;
    logic [BW-1:0]                 in_base;
    logic [LAW-1:0]                rd_addr  [LANES];
    logic                          rd_inr   [LANES];

    // Configuration and device state.
    logic [tbt_pkg::DELAY_W-1:0]   r_start_delay;
    logic                          r_armed,       n_armed;
    logic [BI_W-1:0]               r_byte_index,  n_byte_index;
    logic [tbt_pkg::DELAY_W-1:0]   r_delay_count, n_delay_count;
    logic [LANE_DEPTH-1:0]         r_vld [LANES];

    // Request stage.
    logic                          r_s1_valid;
    logic [tbt_pkg::REQ_W-1:0]     r_s1_req;
    logic [tbt_pkg::OFF_W-1:0]     r_s1_pos;
    logic                          r_s1_ctrl;
    logic [tbt_pkg::DATA_W-1:0]    r_s1_wdata;
    logic [LAW-1:0]                r_s1_laddr [LANES];
    logic                          r_s1_inr   [LANES];
    logic                          r_s1_vld   [LANES];
    logic                          r_byp_hit  [LANES];
    logic [tbt_pkg::BYTE_W-1:0]    r_byp_data [LANES];
    logic [tbt_pkg::BYTE_W-1:0]    ram_q      [LANES];
    logic [tbt_pkg::BYTE_W-1:0]    lane_byte  [LANES];

    // Buffer writes issued by the request stage.
    logic                          wr_en   [LANES];
    logic [tbt_pkg::BYTE_W-1:0]    wr_data [LANES];

    // Result of the request stage.
    logic [tbt_pkg::DATA_W-1:0]    res_rd;
    logic                          res_txv;
    logic [tbt_pkg::BYTE_W-1:0]    res_txb;
    logic [tbt_pkg::DELAY_W-1:0]   tick_delay;

    // Result register.
    logic                          r_out_valid;
    logic [47:0]                   r_out_data;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // Request decode and lane read addresses at accept time
    // ------------------------------------------------------------------------
    assign in_req  = i_s_axis_tuser;
    assign in_off  = i_s_axis_tdata[4:0];
    assign in_ctrl = in_off < tbt_pkg::CTRL_BYTES;
    assign in_pos  = in_ctrl ? '0 : (in_off - tbt_pkg::CTRL_BYTES);
    assign in_word = (in_req == tbt_pkg::REQ_RD_WORD) || (in_req == tbt_pkg::REQ_WR_WORD);
    // A tick reads the byte that the state after the request ahead points at.
    assign in_base = (in_req == tbt_pkg::REQ_TICK) ? BW'(n_byte_index) : BW'(in_pos);

    for (genvar l = 0; l < LANES; l++) begin : g_lane_addr
        logic [1:0]    lane_ofs;
        logic [BW-1:0] lane_b;

        // Byte of the word that falls into this lane.
        assign lane_ofs   = 2'(l) - in_pos[1:0];
        assign lane_b     = in_word ? (BW'(in_pos) + BW'(lane_ofs)) : in_base;
        assign rd_addr[l] = LAW'(lane_b >> 2);
        assign rd_inr[l]  = {1'b0, lane_b} < (BW + 1)'(BUF_BYTES);
    end

    // ------------------------------------------------------------------------
    // Buffer lane memories
    // ------------------------------------------------------------------------
    for (genvar l = 0; l < LANES; l++) begin : g_lane_ram
        tbt_ram #(
            .WIDTH (tbt_pkg::BYTE_W),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[l]),
            .i_wr_addr (r_s1_laddr[l]),
            .i_wr_data (wr_data[l]),
            .i_rd_en   (s_acc),
            .i_rd_addr (rd_addr[l]),
            .o_rd_data (ram_q[l])
        );

        // Never-written bytes read as zero; a write in the accept cycle is forwarded.
        assign lane_byte[l] = r_byp_hit[l]                 ? r_byp_data[l] :
                              (r_s1_inr[l] && r_s1_vld[l]) ? ram_q[l]      : '0;
    end

    // ------------------------------------------------------------------------
    // Request stage registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_req   <= in_req;
            r_s1_pos   <= in_pos;
            r_s1_ctrl  <= in_ctrl;
            r_s1_wdata <= i_s_axis_tdata[36:5];
            for (int l = 0; l < LANES; l++) begin
                r_s1_laddr[l] <= rd_addr[l];
                r_s1_inr[l]   <= rd_inr[l];
                r_s1_vld[l]   <= rd_inr[l] ? r_vld[l][rd_addr[l]] : 1'b0;
                r_byp_hit[l]  <= wr_en[l] && rd_inr[l] && (r_s1_laddr[l] == rd_addr[l]);
                r_byp_data[l] <= wr_data[l];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request processing: state update, buffer writes and result
    // ------------------------------------------------------------------------
    assign tick_delay = (r_delay_count < tbt_pkg::DELAY_MAX) ? (r_delay_count + 16'd1)
                                                             : r_delay_count;

    always_comb begin
        n_armed       = r_armed;
        n_byte_index  = r_byte_index;
        n_delay_count = r_delay_count;
        res_rd        = '0;
        res_txv       = 1'b0;
        res_txb       = '0;
        for (int l = 0; l < LANES; l++) begin
            wr_en[l]   = 1'b0;
            wr_data[l] = 8'(r_s1_wdata >> {2'(l) - r_s1_pos[1:0], 3'b000});
        end

        if (s1_adv) begin
            unique case (tbt_pkg::t_req'(r_s1_req))
                tbt_pkg::REQ_TICK: begin
                    if (r_armed) begin
                        n_delay_count = tick_delay;
                        if (tick_delay > r_start_delay) begin
                            res_txv = 1'b1;
                            res_txb = lane_byte[r_byte_index[1:0]];
                            if (r_byte_index == BI_W'(BUF_BYTES - 1)) begin
                                n_armed       = 1'b0;
                                n_byte_index  = '0;
                                n_delay_count = '0;
                            end else begin
                                n_byte_index = r_byte_index + 1'b1;
                            end
                        end
                    end
                end
                tbt_pkg::REQ_RD_WORD: begin
                    if (r_s1_ctrl) begin
                        res_rd = {31'd0, r_armed};
                    end else begin
                        for (int i = 0; i < LANES; i++) begin
                            res_rd[8*i +: 8] = lane_byte[2'(r_s1_pos[1:0] + 2'(i))];
                        end
                    end
                end
                tbt_pkg::REQ_RD_BYTE: begin
                    res_rd = r_s1_ctrl ? {31'd0, r_armed}
                                       : {24'd0, lane_byte[r_s1_pos[1:0]]};
                end
                tbt_pkg::REQ_WR_WORD: begin
                    if (r_s1_ctrl) begin
                        n_armed = 1'b1;
                    end else begin
                        for (int l = 0; l < LANES; l++) begin
                            wr_en[l] = r_s1_inr[l];
                        end
                    end
                end
                tbt_pkg::REQ_WR_BYTE: begin
                    if (r_s1_ctrl) begin
                        n_armed = 1'b1;
                    end else begin
                        for (int l = 0; l < LANES; l++) begin
                            wr_en[l]   = r_s1_inr[l] && (r_s1_pos[1:0] == 2'(l));
                            wr_data[l] = r_s1_wdata[7:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Device state and configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay <= tbt_pkg::DELAY_RESET;
            r_armed       <= 1'b0;
            r_byte_index  <= '0;
            r_delay_count <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_vld[l] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_start_delay <= i_cfg_data;
            end
            r_armed       <= n_armed;
            r_byte_index  <= n_byte_index;
            r_delay_count <= n_delay_count;
            for (int l = 0; l < LANES; l++) begin
                if (wr_en[l]) begin
                    r_vld[l][r_s1_laddr[l]] <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {6'd0, n_armed, res_txb, res_txv, res_rd};
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The byte pointer only moves while armed and is cleared on disarm.
    a_index_needs_armed : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_index != '0) |-> r_armed
    ) else $error("byte index nonzero while disarmed");

    // The delay counter is cleared whenever the device disarms.
    a_delay_needs_armed : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_delay_count != '0) |-> r_armed
    ) else $error("delay counter nonzero while disarmed");

    // A processed request always lands in the result register.
    a_adv_fills_out : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid
    ) else $error("processed request lost before the result register");

endmodule

/* bench/tb_timed_byte_transmitter_top.sv */
// ============================================================================
// Timed byte transmitter testbench
// Drives bus accesses and ticks into the request stream. A behavioral model of
// the control word, transmit buffer and delay counter predicts every reply.
// Replies are compared field by field in order. The run covers a directed
// table, delay-counter runs at the extreme delays, and four random phases
// with different idle and stall rates.
// ============================================================================
module tb_timed_byte_transmitter_top;

    localparam int unsigned NBYTES    = 16;
    localparam int unsigned WIN_BYTES = 20;
    localparam int          LIMIT     = 1_000_000;
    localparam int          HOLD_LEN  = 300;
    localparam int          PHASE_N   = 350;

    // Request codes that the block does not decode.
    localparam logic [2:0] REQ_SPARE_5 = 3'd5;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    // One reply on the result stream.
    typedef struct packed {
        logic [31:0] rd;
        logic        txv;
        logic [7:0]  txb;
        logic        busy;
    } t_tx_reply;

    // One row of the directed table; want is used only when typed is set.
    typedef struct packed {
        logic [2:0]  req;
        logic [4:0]  off;
        logic [31:0] data;
        logic [7:0]  reps;
        logic        typed;
        t_tx_reply   want;
    } t_dir_row;

    localparam t_tx_reply QUIET   = '{32'h0, 1'b0, 8'h00, 1'b0};
    localparam t_tx_reply ARMED   = '{32'h0, 1'b0, 8'h00, 1'b1};
    localparam t_tx_reply CTRL_RD = '{32'h1, 1'b0, 8'h00, 1'b1};
    localparam t_tx_reply NONE    = '{32'h0, 1'b0, 8'h00, 1'b0};

    localparam int DIR_N = 25;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{tbt_pkg::REQ_RD_WORD, 5'd0,  32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_RD_BYTE, 5'd4,  32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_RD_WORD, 5'd16, 32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_TICK,    5'd0,  32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{REQ_SPARE_5,          5'd31, 32'hFFFF_FFFF, 8'd1,  1'b1, QUIET},
        '{REQ_SPARE_6,          5'd0,  32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{REQ_SPARE_7,          5'd19, 32'hA5A5_A5A5, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_WR_WORD, 5'd4,  32'h0302_0100, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_WORD, 5'd8,  32'h0706_0504, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_WORD, 5'd12, 32'h0B0A_0908, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_WORD, 5'd16, 32'h0F0E_0D0C, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_WORD, 5'd18, 32'hFFFF_FFFF, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_RD_WORD, 5'd18, 32'h0000_0000, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_RD_WORD, 5'd17, 32'h0000_0000, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_BYTE, 5'd31, 32'hFFFF_FFFF, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_RD_BYTE, 5'd31, 32'h0000_0000, 8'd1,  1'b1, QUIET},
        '{tbt_pkg::REQ_RD_BYTE, 5'd19, 32'h0000_0000, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_BYTE, 5'd4,  32'hFFFF_FF80, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_WR_BYTE, 5'd2,  32'h0000_0000, 8'd1,  1'b1, ARMED},
        '{tbt_pkg::REQ_RD_BYTE, 5'd3,  32'h0000_0000, 8'd1,  1'b1, CTRL_RD},
        '{tbt_pkg::REQ_WR_WORD, 5'd0,  32'hFFFF_FFFF, 8'd1,  1'b1, ARMED},
        '{tbt_pkg::REQ_RD_WORD, 5'd1,  32'h0000_0000, 8'd1,  1'b1, CTRL_RD},
        '{tbt_pkg::REQ_TICK,    5'd0,  32'h0000_0000, 8'd15, 1'b0, NONE},
        '{tbt_pkg::REQ_TICK,    5'd7,  32'h0000_0000, 8'd1,  1'b0, NONE},
        '{tbt_pkg::REQ_TICK,    5'd0,  32'h0000_0000, 8'd1,  1'b1, QUIET}
    };

    // Block ports.
    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] s_data         = '0;
    logic [2:0]  s_user         = '0;
    logic        o_m_axis_tvalid;
    logic        m_ready        = 1'b1;
    logic [47:0] o_m_axis_tdata;
    logic        cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] cfg_data       = '0;

    // Behavioral model of the transmitter.
    logic [15:0] mdl_delay;
    logic        mdl_armed;
    int unsigned mdl_index;
    logic [15:0] mdl_count;
    logic [7:0]  mdl_buf [NBYTES];

    t_tx_reply   reply_q [$];
    int          err_cnt   = 0;
    int          cycle_cnt = 0;
    int          idle_pct_s = 0;
    int          idle_pct_r = 0;
    int          hold_req   = 0;

    timed_byte_transmitter_top #(
        .BUF_BYTES (NBYTES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reads a buffer byte by window position; positions past the end read zero.
    function automatic logic [7:0] buf_byte(int unsigned pos);
        if (pos < NBYTES) return mdl_buf[pos];
        return 8'h00;
    endfunction

    // Applies one access to the model and returns the reply it produces.
    function automatic t_tx_reply apply_access(logic [2:0] req, logic [4:0] off,
                                               logic [31:0] wdata);
        t_tx_reply   r;
        logic        ctrl;
        int unsigned pos;
        r    = '0;
        ctrl = (off < tbt_pkg::CTRL_BYTES);
        pos  = ctrl ? 0 : int'(off) - int'(tbt_pkg::CTRL_BYTES);
        case (req)
            tbt_pkg::REQ_TICK: begin
                if (mdl_armed) begin
                    if (mdl_count != tbt_pkg::DELAY_MAX) mdl_count++;
                    if (mdl_count > mdl_delay) begin
                        r.txv = 1'b1;
                        r.txb = buf_byte(mdl_index);
                        mdl_index++;
                        if (mdl_index >= NBYTES) begin
                            mdl_armed = 1'b0;
                            mdl_index = 0;
                            mdl_count = '0;
                        end
                    end
                end
            end
            tbt_pkg::REQ_RD_WORD: begin
                if (ctrl) r.rd = {31'b0, mdl_armed};
                else
                    for (int i = 0; i < 4; i++) r.rd[8*i +: 8] = buf_byte(pos + i);
            end
            tbt_pkg::REQ_RD_BYTE: begin
                r.rd = ctrl ? {31'b0, mdl_armed} : {24'b0, buf_byte(pos)};
            end
            tbt_pkg::REQ_WR_WORD: begin
                if (ctrl) mdl_armed = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        if (pos + i < NBYTES) mdl_buf[pos + i] = wdata[8*i +: 8];
            end
            tbt_pkg::REQ_WR_BYTE: begin
                if (ctrl) mdl_armed = 1'b1;
                else if (pos < NBYTES) mdl_buf[pos] = wdata[7:0];
            end
            default: ;
        endcase
        r.busy = mdl_armed;
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Offers one request and waits for its transaction; called at a falling edge.
    task automatic send_access(logic [2:0] req, logic [4:0] off, logic [31:0] wdata,
                               logic typed, t_tx_reply want);
        t_tx_reply r;
        while (idle_pct_s != 0 && $urandom_range(99) < idle_pct_s) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= {3'b0, wdata, off};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        r = apply_access(req, off, wdata);
        reply_q.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    // Stops offering requests and waits until every reply has arrived.
    task automatic drain_replies();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Writes start_delay while the block is idle.
    task automatic write_delay(logic [15:0] v);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_delay = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random access, mostly buffer fills, arming and ticks; some noise.
    task automatic send_random();
        int          pick;
        logic [2:0]  req;
        logic [4:0]  off;
        logic [31:0] d;
        pick = $urandom_range(99);
        d    = $urandom();
        off  = 5'($urandom_range(4, WIN_BYTES - 1));
        if (pick < 45)      req = tbt_pkg::REQ_TICK;
        else if (pick < 58) req = tbt_pkg::REQ_WR_BYTE;
        else if (pick < 68) req = tbt_pkg::REQ_WR_WORD;
        else if (pick < 73) begin
            req = $urandom_range(1) ? tbt_pkg::REQ_WR_BYTE : tbt_pkg::REQ_WR_WORD;
            off = 5'($urandom_range(0, 3));
        end
        else if (pick < 83) begin
            req = tbt_pkg::REQ_RD_BYTE;
            off = 5'($urandom_range(0, WIN_BYTES - 1));
        end
        else if (pick < 92) begin
            req = tbt_pkg::REQ_RD_WORD;
            off = 5'($urandom_range(0, WIN_BYTES - 1));
        end
        else begin
            req = 3'($urandom_range(7));
            off = 5'($urandom_range(31));
        end
        send_access(req, off, d, 1'b0, NONE);
    endtask

    // Receiver readiness, with an occasional long hold-off on request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else begin
                m_ready <= ($urandom_range(99) >= idle_pct_r);
            end
        end
    end

    // Reply checker: every accepted reply is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_tx_reply want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (reply_q.size() == 0) begin
                report_mismatch("reply with none pending", o_m_axis_tdata[31:0], '0);
            end
            else begin
                want = reply_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.rd)
                    report_mismatch("read_data", o_m_axis_tdata[31:0], want.rd);
                if (o_m_axis_tdata[32] !== want.txv)
                    report_mismatch("tx_valid", 32'(o_m_axis_tdata[32]), 32'(want.txv));
                if (o_m_axis_tdata[40:33] !== want.txb)
                    report_mismatch("tx_byte", 32'(o_m_axis_tdata[40:33]), 32'(want.txb));
                if (o_m_axis_tdata[41] !== want.busy)
                    report_mismatch("busy", 32'(o_m_axis_tdata[41]), 32'(want.busy));
            end
        end
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("tb_timed_byte_transmitter_top: FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        mdl_delay = tbt_pkg::DELAY_RESET;
        mdl_armed = 1'b0;
        mdl_index = 0;
        mdl_count = '0;
        foreach (mdl_buf[i]) mdl_buf[i] = 8'h00;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, with the shortest delay so bytes leave on the first tick.
        write_delay(16'd0);
        foreach (DIR_TAB[k])
            for (int n = 0; n < DIR_TAB[k].reps; n++)
                send_access(DIR_TAB[k].req, DIR_TAB[k].off, DIR_TAB[k].data,
                            DIR_TAB[k].typed, DIR_TAB[k].want);

        // Largest legal delay: the counter stays below it for this run.
        write_delay(16'd65534);
        send_access(tbt_pkg::REQ_WR_WORD, 5'd3, $urandom(), 1'b0, NONE);
        for (int n = 0; n < 100; n++)
            send_access(tbt_pkg::REQ_TICK, 5'd0, 32'h0, 1'b0, NONE);

        // Delay at the counter's top: nothing is sent while it stays there.
        write_delay(16'hFFFF);
        send_access(tbt_pkg::REQ_WR_BYTE, 5'd0, $urandom(), 1'b0, NONE);
        for (int n = 0; n < 100; n++)
            send_access(tbt_pkg::REQ_TICK, 5'd0, 32'h0, 1'b0, NONE);
        send_access(tbt_pkg::REQ_RD_WORD, 5'd0, 32'h0, 1'b0, NONE);

        // A lower delay lets the counter that already passed it release the buffer.
        write_delay(16'd100);
        for (int n = 0; n < NBYTES + 2; n++)
            send_access(tbt_pkg::REQ_TICK, 5'd0, 32'h0, 1'b0, NONE);

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct_s = 0;  idle_pct_r = 0;
                    write_delay(16'd0);
                end
                1: begin
                    idle_pct_s = 49; idle_pct_r = 0;
                    write_delay(16'd3);
                end
                2: begin
                    idle_pct_s = 0;  idle_pct_r = 49;
                    write_delay(16'($urandom_range(0, 25)));
                end
                default: begin
                    idle_pct_s = 17; idle_pct_r = 17;
                    write_delay(16'd12);
                end
            endcase
            for (int n = 0; n < PHASE_N; n++) begin
                // Hold the receiver off for a long stretch while requests keep coming.
                if (ph == 0 && n == 100) hold_req++;
                // Pause the sender until every reply is back.
                if (n == PHASE_N / 2) drain_replies();
                send_random();
            end
        end

        drain_replies();
        repeat (10) @(negedge i_clk);
        if (err_cnt == 0)
            $display("tb_timed_byte_transmitter_top: PASS");
        else
            $display("tb_timed_byte_transmitter_top: FAIL");
        $finish;
    end

endmodule
